// ===== design/pcbfm_pkg.sv =====
// Package for the per-core busy fraction meter.
// Holds payload structs, status codes, controller states and control/status bundles.
// No dependencies.
package pcbfm_pkg;

  localparam int CORE_W = 7;
  localparam int TICK_W = 32;
  localparam int FRAC_W = 16;
  localparam int STAT_W = 2;
  localparam int CCNT_W = 8;

  // number of pair-add steps that fold the eight counters into the total
  localparam int SUM_STEPS = 4;

  localparam logic [STAT_W-1:0] STATUS_VALID = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_FIRST = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_ZERO  = 2'd2;
  localparam logic [STAT_W-1:0] STATUS_BAD   = 2'd3;

  localparam logic [CCNT_W-1:0] CORE_COUNT_RESET = 8'd128;

  typedef struct packed {
    logic [CORE_W-1:0] core_index;
    logic [TICK_W-1:0] user_ticks;
    logic [TICK_W-1:0] nice_ticks;
    logic [TICK_W-1:0] system_ticks;
    logic [TICK_W-1:0] idle_ticks;
    logic [TICK_W-1:0] iowait_ticks;
    logic [TICK_W-1:0] irq_ticks;
    logic [TICK_W-1:0] softirq_ticks;
    logic [TICK_W-1:0] steal_ticks;
  } sample_t;

  typedef struct packed {
    logic [CORE_W-1:0] result_core;
    logic [FRAC_W-1:0] busy_fraction;
    logic [STAT_W-1:0] status_code;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DELTA,
    ST_PREP,
    ST_DIVIDE,
    ST_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic load;      // capture sample, read history
    logic sum_step;  // fold one counter pair into the total
    logic delta;     // form deltas, write back history
    logic prep;      // classify, seed divider
    logic div_step;  // one restoring-division step
  } dp_cmd_t;

  typedef struct packed {
    logic bad;       // index rejected at load
    logic skip_div;  // result settled without division
  } dp_stat_t;

endpackage

// ===== design/pcbfm_dp.sv =====
// Datapath of the busy fraction meter: sample capture, sum adder, history memory,
// delta logic and a bit-serial restoring divider.
// Depends on pcbfm_pkg.
module pcbfm_dp #(
  parameter int DEPTH     = 128,
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  pcbfm_pkg::sample_t        in_item,
  input  logic [pcbfm_pkg::CCNT_W-1:0] core_count,
  input  pcbfm_pkg::dp_cmd_t        cmd,
  output pcbfm_pkg::dp_stat_t       stat,
  output pcbfm_pkg::result_t        result
);
  import pcbfm_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [2*TICK_W-1:0] hist_mem [DEPTH];
  logic [2*TICK_W-1:0] hist_rd;
  logic [DEPTH-1:0]    seen;
  logic                seen_prev;

  logic [2*TICK_W-1:0] pair [SUM_STEPS];
  logic [TICK_W-1:0]   total_sum;
  logic [TICK_W-1:0]   idle_sum;
  logic [TICK_W-1:0]   d_total;
  logic [TICK_W-1:0]   d_idle;
  logic [TICK_W-1:0]   rem;
  logic [FRAC_BITS-1:0] quo;
  logic [CORE_W-1:0]   core;
  logic [AW-1:0]       addr;
  logic [STAT_W-1:0]   status;
  logic                bad;

  logic [AW-1:0]       in_addr;
  logic                in_bad;
  logic                is_zero;
  logic                is_sat;
  logic [TICK_W:0]     rem_shift;
  logic [TICK_W:0]     rem_diff;
  logic [FRAC_BITS+FRAC_W-1:0] frac_ext;

  assign in_addr = in_item.core_index[AW-1:0];
  assign in_bad  = ({1'b0, in_item.core_index} >= core_count) ||
                   (32'(in_item.core_index) >= 32'(DEPTH));

  // busy = d_total - d_idle saturates exactly when idle delta is zero or
  // exceeds the total delta (wrapped busy then lands at or above the total)
  assign is_zero = (d_total == '0);
  assign is_sat  = (d_idle == '0) || (d_idle > d_total);

  assign stat.bad      = bad;
  assign stat.skip_div = !seen_prev || is_zero || is_sat;

  assign rem_shift = {rem, 1'b0};
  assign rem_diff  = rem_shift - {1'b0, d_total};

  // history memory, one read at load, one write at delta
  always_ff @(posedge clk) begin
    if (cmd.load && !in_bad) begin
      hist_rd <= hist_mem[in_addr];
    end
    if (cmd.delta) begin
      hist_mem[addr] <= {idle_sum, total_sum};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen      <= '0;
      seen_prev <= 1'b0;
    end else begin
      if (cmd.load && !in_bad) begin
        seen_prev <= seen[in_addr];
      end
      if (cmd.delta) begin
        seen[addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      core      <= in_item.core_index;
      addr      <= in_addr;
      bad       <= in_bad;
      status    <= in_bad ? STATUS_BAD : STATUS_VALID;
      quo       <= '0;
      total_sum <= '0;
      idle_sum  <= in_item.idle_ticks + in_item.iowait_ticks;
      pair[0]   <= {in_item.user_ticks, in_item.nice_ticks};
      pair[1]   <= {in_item.system_ticks, in_item.idle_ticks};
      pair[2]   <= {in_item.iowait_ticks, in_item.irq_ticks};
      pair[3]   <= {in_item.softirq_ticks, in_item.steal_ticks};
    end
    if (cmd.sum_step) begin
      total_sum <= total_sum + pair[0][2*TICK_W-1:TICK_W] + pair[0][TICK_W-1:0];
      for (int i = 0; i < SUM_STEPS - 1; i++) begin
        pair[i] <= pair[i+1];
      end
    end
    if (cmd.delta) begin
      d_total <= total_sum - hist_rd[TICK_W-1:0];
      d_idle  <= idle_sum - hist_rd[2*TICK_W-1:TICK_W];
    end
    if (cmd.prep) begin
      rem <= d_total - d_idle;
      if (!seen_prev) begin
        status <= STATUS_FIRST;
      end else if (is_zero) begin
        status <= STATUS_ZERO;
      end else begin
        status <= STATUS_VALID;
        if (is_sat) begin
          quo <= '1;
        end
      end
    end
    if (cmd.div_step) begin
      if (!rem_diff[TICK_W]) begin
        rem <= rem_diff[TICK_W-1:0];
        quo <= {quo[FRAC_BITS-2:0], 1'b1};
      end else begin
        rem <= rem_shift[TICK_W-1:0];
        quo <= {quo[FRAC_BITS-2:0], 1'b0};
      end
    end
  end

  assign frac_ext = {{FRAC_W{1'b0}}, quo};

  assign result.result_core   = core;
  assign result.busy_fraction = frac_ext[FRAC_W-1:0];
  assign result.status_code   = status;

endmodule

// ===== design/pcbfm_ctrl.sv =====
// Controller of the busy fraction meter: sequences load, sum, delta, prep,
// divide and report phases.
// Depends on pcbfm_pkg.
module pcbfm_ctrl #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  pcbfm_pkg::dp_stat_t stat,
  output pcbfm_pkg::dp_cmd_t  cmd,
  output logic                busy,
  output logic                done
);
  import pcbfm_pkg::*;

  localparam int CW = $clog2(FRAC_BITS);

  ctrl_state_t   state;
  ctrl_state_t   state_next;
  logic [CW-1:0] step;
  logic [CW-1:0] step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_SUM;
        end
      end
      ST_SUM: begin
        if (stat.bad) begin
          state_next = ST_DONE;
        end else if (step == CW'(SUM_STEPS - 1)) begin
          state_next = ST_DELTA;
        end
      end
      ST_DELTA: begin
        state_next = ST_PREP;
      end
      ST_PREP: begin
        state_next = stat.skip_div ? ST_DONE : ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (step == CW'(FRAC_BITS - 1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // step counts within a phase, restarting on every state change
  assign step_next = (state_next != state) ? '0 : step + CW'(1);

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    done = 1'b0;
    case (state)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_SUM: begin
        cmd.sum_step = !stat.bad;
      end
      ST_DELTA: begin
        cmd.delta = 1'b1;
      end
      ST_PREP: begin
        cmd.prep = 1'b1;
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
      end
      ST_DONE: begin
        done = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule

// ===== design/per_core_busy_fraction_meter.sv =====
// Top level of the per-core busy fraction meter: core_count register,
// controller and datapath.
// Depends on pcbfm_pkg, pcbfm_ctrl, pcbfm_dp.
//
// Usage:
//  - Input beat: drive in_item (core index plus eight cumulative tick
//    counters) and raise start; the beat is taken at an edge where start is
//    high and busy is low. busy stays high until the result has been shown.
//  - Output beat: done is high for exactly one cycle with result valid in that
//    cycle. The receiver cannot stall; the result must be taken then.
//  - Config: cfg_we with cfg_data writes core_count; only while busy is low.
//  - Sequence after the accepting edge: a bad index goes from the sum phase
//    straight to done; a first sample, a zero interval or a saturated share
//    ends after prep without division; a normal result runs the sum, delta,
//    prep and divide phases before done. The total is formed by the
//    four-step pair adder and the fraction by the one-bit-per-cycle restoring
//    divider. A new item is taken only after done, once busy is low again.
//  - Reset: core_count returns to 128, every core is marked unseen so its next
//    sample only records history; the history memory itself is not cleared.
module per_core_busy_fraction_meter #(
  parameter int MAX_CORES     = 128,
  parameter int FRACTION_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  pcbfm_pkg::sample_t           in_item,
  output logic                         done,
  output pcbfm_pkg::result_t           result,
  input  logic                         cfg_we,
  input  logic [pcbfm_pkg::CCNT_W-1:0] cfg_data
);
  import pcbfm_pkg::*;

  // the 7-bit index never reaches past 128 entries
  localparam int DEPTH = (MAX_CORES < 128) ? MAX_CORES : 128;

  logic [CCNT_W-1:0] core_count;
  dp_cmd_t           cmd;
  dp_stat_t          stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      core_count <= CORE_COUNT_RESET;
    end else if (cfg_we) begin
      core_count <= cfg_data;
    end
  end

  pcbfm_ctrl #(
    .FRAC_BITS (FRACTION_BITS)
  ) u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  pcbfm_dp #(
    .DEPTH     (DEPTH),
    .FRAC_BITS (FRACTION_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .in_item    (in_item),
    .core_count (core_count),
    .cmd        (cmd),
    .stat       (stat),
    .result     (result)
  );

  // accepted beat keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  // result strobe lasts one cycle and frees the block
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> (!done && !busy))
    else $error("done not a single-cycle strobe ending busy");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("done outside a busy interval");

  // only valid results carry a nonzero fraction
  a_frac_status: assert property (@(posedge clk) disable iff (rst)
    (done && result.status_code != STATUS_VALID) |-> (result.busy_fraction == '0))
    else $error("nonzero fraction on a non-valid result");

endmodule

// ===== test/per_core_busy_fraction_meter_tb.sv =====
// Self-checking testbench for per_core_busy_fraction_meter: drives tick-counter samples,
// predicts each core's busy fraction and status, and checks every result beat.
// Depends on pcbfm_pkg and the per_core_busy_fraction_meter RTL.
module per_core_busy_fraction_meter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pcbfm_pkg::*;

  // The limit lies well above the slowest legal run, leaving a wide margin.
  localparam int CYCLE_LIMIT = 400000;
  localparam int CORES       = 128;
  localparam int REPORT_MAX  = 10;
  // Covers the slowest item (normal result) plus slack.
  localparam int TAIL_CYCLES = 32;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  sample_t             in_item = '0;
  logic                done;
  result_t             result;
  logic                cfg_we = 1'b0;
  logic [CCNT_W-1:0]   cfg_data = '0;

  per_core_busy_fraction_meter uut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .in_item (in_item),
    .done    (done),
    .result  (result),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: our own copy of the core_count register and per-core history.
  // ---------------------------------------------------------------------------
  logic [CCNT_W-1:0]   core_count_shadow = CORE_COUNT_RESET;
  logic [TICK_W-1:0]   last_idle_sum  [CORES];
  logic [TICK_W-1:0]   last_total_sum [CORES];
  logic                core_has_history [CORES];

  // Stimulus side: last counters sent per core, so random sequences stay well formed.
  logic [TICK_W-1:0]   sent_ticks [CORES][8];

  sample_t             pending_samples [$];
  result_t             awaited_results [$];

  int                  sender_idle_pct = 0;
  logic                drain_hold = 1'b0;
  int                  mismatch_count = 0;
  int                  error_count = 0;
  int                  cycle_count = 0;

  // Busy fraction of one sample, in Q0.16, plus its status. Updates the history of
  // the core unless the index is rejected.
  function automatic result_t predict_busy_fraction(input sample_t s);
    result_t            r;
    logic [TICK_W-1:0]  idle_sum;
    logic [TICK_W-1:0]  total_sum;
    logic [TICK_W-1:0]  d_total;
    logic [TICK_W-1:0]  d_idle;
    logic [TICK_W-1:0]  d_busy;
    logic [63:0]        quot;
    r.result_core   = s.core_index;
    r.busy_fraction = '0;
    r.status_code   = STATUS_VALID;
    if ({1'b0, s.core_index} >= core_count_shadow) begin
      r.status_code = STATUS_BAD;
      return r;
    end
    idle_sum  = s.idle_ticks + s.iowait_ticks;
    total_sum = s.user_ticks + s.nice_ticks + s.system_ticks + s.idle_ticks +
                s.iowait_ticks + s.irq_ticks + s.softirq_ticks + s.steal_ticks;
    if (!core_has_history[s.core_index]) begin
      r.status_code = STATUS_FIRST;
    end else begin
      d_total = total_sum - last_total_sum[s.core_index];
      d_idle  = idle_sum - last_idle_sum[s.core_index];
      if (d_total == '0) begin
        r.status_code = STATUS_ZERO;
      end else begin
        d_busy = d_total - d_idle;
        // busy >= total covers both a full share and a wrapped (idle > total) delta
        if (d_busy >= d_total) begin
          r.busy_fraction = '1;
        end else begin
          quot = {d_busy, 16'b0} / {32'b0, d_total};
          r.busy_fraction = (quot > 64'hFFFF) ? '1 : quot[FRAC_W-1:0];
        end
      end
    end
    last_idle_sum[s.core_index]    = idle_sum;
    last_total_sum[s.core_index]   = total_sum;
    core_has_history[s.core_index] = 1'b1;
    return r;
  endfunction

  function automatic sample_t sample_of(input logic [CORE_W-1:0] core,
                                        input logic [TICK_W-1:0] usr, nic, sys, idl,
                                        input logic [TICK_W-1:0] iow, irq, sirq, stl);
    sample_t s;
    s.core_index    = core;
    s.user_ticks    = usr;
    s.nice_ticks    = nic;
    s.system_ticks  = sys;
    s.idle_ticks    = idl;
    s.iowait_ticks  = iow;
    s.irq_ticks     = irq;
    s.softirq_ticks = sirq;
    s.steal_ticks   = stl;
    return s;
  endfunction

  // Mostly counters that advance from the core's previous sample; a share of
  // zero intervals, idle-only, busy-only, idle-over-total, huge jumps, noise
  // and out-of-range indices.
  function automatic sample_t next_tick_sample(input logic [CCNT_W-1:0] cc);
    logic [CORE_W-1:0]  core;
    logic [TICK_W-1:0]  t [8];
    logic [TICK_W-1:0]  a;
    logic [TICK_W-1:0]  b;
    int unsigned        scale;
    int                 lim;
    int                 mode;
    int                 k;
    mode = $urandom_range(0, 99);
    lim  = (cc > CORES) ? CORES : int'(cc);
    if (lim == 0 || mode >= 92) begin
      core = CORE_W'($urandom_range(0, CORES - 1));
    end else begin
      core = CORE_W'($urandom_range(0, lim - 1));
    end
    case ($urandom_range(0, 2))
      0:       scale = 16;
      1:       scale = 4096;
      default: scale = 1 << 24;
    endcase
    for (k = 0; k < 8; k++) t[k] = sent_ticks[core][k];
    if (mode < 60 || mode >= 92) begin
      for (k = 0; k < 8; k++) t[k] += $urandom_range(0, scale);
    end else if (mode < 65) begin
      // zero interval: unchanged, or one counter moves against another
      if ($urandom_range(0, 1)) begin
        a = $urandom_range(1, scale);
        t[0] += a;
        t[2] -= a;
      end
    end else if (mode < 70) begin
      t[3] += $urandom_range(1, scale);
      t[4] += $urandom_range(0, scale);
    end else if (mode < 75) begin
      t[0] += $urandom_range(1, scale);
      t[6] += $urandom_range(0, scale);
    end else if (mode < 80) begin
      // idle grows more than the total does
      a = $urandom_range(2, scale);
      b = $urandom_range(1, a - 1);
      t[3] += a;
      t[0] -= b;
    end else if (mode < 85) begin
      for (k = 0; k < 8; k++) t[k] += $urandom();
    end else begin
      for (k = 0; k < 8; k++) t[k] = $urandom();
    end
    for (k = 0; k < 8; k++) sent_ticks[core][k] = t[k];
    return sample_of(core, t[0], t[1], t[2], t[3], t[4], t[5], t[6], t[7]);
  endfunction

  // Block is idle: nothing queued, nothing presented, nothing outstanding. A beat
  // picked at an edge shows on start only after that edge, so a single quiet edge
  // is not enough; the block has to look quiet on successive edges.
  task automatic wait_for_drain();
    int quiet_edges;
    quiet_edges = 0;
    while (quiet_edges < 2) begin
      @(posedge clk);
      if (pending_samples.size() != 0 || start || awaited_results.size() != 0 || busy)
        quiet_edges = 0;
      else
        quiet_edges++;
    end
  endtask

  // Register write only while idle; the shadow follows at the capturing edge.
  task automatic write_core_count(input logic [CCNT_W-1:0] value);
    wait_for_drain();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    core_count_shadow = value;
  endtask

  task automatic run_random_phase(input logic [CCNT_W-1:0] cc, input int idle_pct,
                                  input int beats);
    int n;
    write_core_count(cc);
    sender_idle_pct = idle_pct;
    for (n = 0; n < beats; n++) pending_samples.push_back(next_tick_sample(cc));
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents one beat at a time. A new beat is only picked once the
  // current one has been taken (or none is up), so start holds until its beat is taken.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive
    logic accepted;
    accepted = start && !busy;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (accepted) awaited_results.push_back(predict_busy_fraction(in_item));
      if (!start || accepted) begin
        // occasional full drain: hold off until every result is back
        if (drain_hold && awaited_results.size() == 0) drain_hold = 1'b0;
        if (!drain_hold && pending_samples.size() != 0 && $urandom_range(0, 63) == 0)
          drain_hold = 1'b1;
        if (!drain_hold && pending_samples.size() != 0 &&
            $urandom_range(0, 99) >= sender_idle_pct) begin
          in_item <= pending_samples.pop_front();
          start   <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: done marks a result beat; it cannot be stalled, so it is taken now.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch
    result_t want;
    if (!rst && done) begin
      if (awaited_results.size() == 0) begin
        error_count++;
        if (error_count + mismatch_count <= REPORT_MAX)
          $display("ERROR: unexpected result core=%0d frac=%0d status=%0d",
                   result.result_core, result.busy_fraction, result.status_code);
      end else begin
        want = awaited_results.pop_front();
        if (result.result_core !== want.result_core ||
            result.busy_fraction !== want.busy_fraction ||
            result.status_code !== want.status_code) begin
          mismatch_count++;
          if (error_count + mismatch_count <= REPORT_MAX)
            $display("MISMATCH: core exp %0d got %0d, frac exp %0d got %0d, status exp %0d got %0d",
                     want.result_core, result.result_core,
                     want.busy_fraction, result.busy_fraction,
                     want.status_code, result.status_code);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed cases, then random phases over several settings.
  // ---------------------------------------------------------------------------
  initial begin : sequence_main
    int c;
    int k;
    for (c = 0; c < CORES; c++) begin
      core_has_history[c] = 1'b0;
      for (k = 0; k < 8; k++) sent_ticks[c][k] = $urandom();
    end
    rst <= 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed, core_count at its reset value.
    pending_samples.push_back(sample_of(7'd0, 0, 0, 0, 0, 0, 0, 0, 0));     // first sample
    pending_samples.push_back(sample_of(7'd0, 0, 0, 0, 0, 0, 0, 0, 0));     // zero interval
    pending_samples.push_back(sample_of(7'd0, 100, 0, 0, 100, 0, 0, 0, 0)); // half busy
    pending_samples.push_back(sample_of(7'd0, 100, 0, 0, 300, 0, 0, 0, 0)); // all idle
    pending_samples.push_back(sample_of(7'd0, 400, 0, 0, 300, 0, 0, 0, 0)); // full share
    pending_samples.push_back(sample_of(7'd0, 390, 0, 0, 320, 0, 0, 0, 0)); // idle over total
    pending_samples.push_back(sample_of(7'd0, 391, 0, 0, 32'h8000013F, 0, 0, 0, 0)); // tiny
    pending_samples.push_back(sample_of(7'd127, '1, '1, '1, '1, '1, '1, '1, '1));
    pending_samples.push_back(sample_of(7'd127, 0, 0, 0, 0, 0, 0, 0, 0));   // sums wrap
    pending_samples.push_back(sample_of(7'd127, '1, '1, '1, '1, '1, '1, '1, '1));
    pending_samples.push_back(sample_of(7'd64, 32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA,
                                        32'h55555555, 32'hAAAAAAAA, 32'h55555555,
                                        32'hAAAAAAAA, 32'h55555555));
    pending_samples.push_back(sample_of(7'd64, 32'h55555555, 32'hAAAAAAAA, 32'h55555555,
                                        32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA,
                                        32'h55555555, 32'hAAAAAAAA));
    pending_samples.push_back(sample_of(7'd1, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_samples.push_back(sample_of(7'd1, 0, 1, 1, 0, 1, 1, 1, 1));     // iowait is idle

    // Smallest core_count: only core 0 is accepted.
    write_core_count(8'd1);
    pending_samples.push_back(sample_of(7'd0, 500, 0, 0, 400, 0, 0, 0, 0));
    pending_samples.push_back(sample_of(7'd1, 1, 2, 3, 4, 5, 6, 7, 8));
    pending_samples.push_back(sample_of(7'd127, '1, '1, '1, '1, '1, '1, '1, '1));

    // Zero cores: every index is rejected.
    write_core_count(8'd0);
    pending_samples.push_back(sample_of(7'd0, 600, 0, 0, 400, 0, 0, 0, 0));

    // Register at its maximum: every 7-bit index is in range.
    write_core_count(8'd255);
    pending_samples.push_back(sample_of(7'd127, 5, 0, 0, 0, 0, 0, 0, 3));
    pending_samples.push_back(sample_of(7'd100, 9, 9, 9, 9, 9, 9, 9, 9));

    // Random phases: sender idle 0, 72 and 26 percent over several settings.
    run_random_phase(8'd128, 0, 300);
    run_random_phase(8'd4, 72, 250);
    run_random_phase(8'd1, 26, 200);
    run_random_phase(8'd37, 0, 250);
    run_random_phase(8'd255, 72, 250);
    run_random_phase(8'd0, 26, 50);
    run_random_phase(CCNT_W'($urandom_range(1, 128)), 0, 300);

    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (awaited_results.size() != 0) error_count++;
    if (error_count == 0 && mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
